/* rtl/skxc_pkg.sv */
`default_nettype none

package skxc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned TableWords = 55;

  localparam logic [IdxW-1:0] LastIdx    = 6'd54;
  localparam logic [IdxW-1:0] LongLag    = 6'd31;
  localparam logic [IdxW-1:0] ShortLag   = 6'd24;
  localparam logic [IdxW-1:0] SeedStride = 6'd21;

  localparam logic [1:0] RekeyPasses = 2'd3;
  localparam logic [1:0] CryptPasses = 2'd0;

  typedef enum logic {
    OP_REKEY = 1'b0,
    OP_CRYPT = 1'b1
  } op_t;

endpackage

`default_nettype wire

/* rtl/skxc_if.sv */
`default_nettype none

interface skxc_in_if;
  logic                       valid;
  logic                       ready;
  logic [0:0]                 opcode;
  logic [skxc_pkg::WordW-1:0] data_word;
  logic [0:0]                 last_word;

  modport source (output valid, output opcode, output data_word, output last_word,
                  input ready);
  modport sink (input valid, input opcode, input data_word, input last_word,
                output ready);
endinterface

interface skxc_out_if;
  logic                       valid;
  logic                       ready;
  logic [skxc_pkg::WordW-1:0] result_word;
  logic [0:0]                 last_out;

  modport source (output valid, output result_word, output last_out, input ready);
  modport sink (input valid, input result_word, input last_out, output ready);
endinterface

interface skxc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [skxc_pkg::WordW-1:0] seed_key;

  modport source (output valid, output seed_key, input ready);
  modport sink (input valid, input seed_key, output ready);
endinterface

`default_nettype wire

/* rtl/skxc_ram.sv */
`default_nettype none

module skxc_ram #(
  parameter int unsigned Width = skxc_pkg::WordW,
  parameter int unsigned Depth = skxc_pkg::TableWords,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr_a,
  input  logic [AddrW-1:0] raddr_b,
  output logic [Width-1:0] rdata_a,
  output logic [Width-1:0] rdata_b
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_a_r;
  logic [Width-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

/* rtl/subtractive_keystream_xor_cipher_core.sv */
`default_nettype none

// XOR stream cipher fed by a 55-word lagged subtractive generator. The table sits in a
// two-read, one-write RAM and a subtractor walks it under a small sequencer;
// the block takes one transaction at a time. A crypt transaction reads its keystream
// word, posts its result and returns to idle; on the first word after reset or a rekey
// and after every 55th word it first mixes the table once, reading each entry and
// then subtracting and writing it back. A rekey transaction runs the seeding walk over
// all 55 entries, four mixing passes, posts its result (zero) and returns to idle.
// Posting holds while an earlier result still waits in the result register. That
// register lets a new transaction be accepted while a result waits to be taken.
// seed_key may be written at any time the block is idle; until the first rekey the
// keystream comes from the all-zero table.

module subtractive_keystream_xor_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  skxc_in_if.sink     in_ch,
  skxc_out_if.source  out_ch,
  skxc_cfg_if.sink    cfg_ch
);

  localparam int unsigned WordW = skxc_pkg::WordW;
  localparam int unsigned IdxW  = skxc_pkg::IdxW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_MIX_RD,
    S_MIX_WR,
    S_RD,
    S_OUT
  } state_t;

  state_t              state_r;
  skxc_pkg::op_t       op_r;
  logic [WordW-1:0]    data_r;
  logic                last_r;
  logic [WordW-1:0]    seed_key_r;

  logic [IdxW-1:0]     k_r;
  logic [IdxW-1:0]     pos_r;
  logic [WordW-1:0]    prev_r;
  logic [WordW-1:0]    cur_r;

  logic [IdxW-1:0]     mi_r;
  logic [1:0]          pass_r;
  logic [IdxW-1:0]     rd_idx_r;
  logic                mix_pend_r;

  logic                tbl_vld_r [skxc_pkg::TableWords];
  logic                vld_a_r;
  logic                vld_b_r;

  logic                out_vld_r;
  logic [WordW-1:0]    result_r;
  logic                last_out_r;

  logic                we;
  logic [IdxW-1:0]     waddr;
  logic [WordW-1:0]    wdata;
  logic [IdxW-1:0]     raddr_a;
  logic [IdxW-1:0]     raddr_b;
  logic [WordW-1:0]    rdata_a;
  logic [WordW-1:0]    rdata_b;
  logic [WordW-1:0]    rd_a;
  logic [WordW-1:0]    rd_b;
  logic [IdxW-1:0]     mix_other;
  logic [IdxW:0]       pos_sum;
  logic [IdxW:0]       pos_wrap;
  logic [IdxW-1:0]     pos_nxt;
  logic                in_acc;
  logic                out_free;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;

  assign mix_other = (mi_r < skxc_pkg::ShortLag) ? mi_r + skxc_pkg::LongLag
                                                 : mi_r - skxc_pkg::ShortLag;

  assign pos_sum  = {1'b0, pos_r} + {1'b0, skxc_pkg::SeedStride};
  assign pos_wrap = (pos_sum >= (IdxW+1)'(skxc_pkg::TableWords))
                  ? pos_sum - (IdxW+1)'(skxc_pkg::TableWords) : pos_sum;
  assign pos_nxt  = pos_wrap[IdxW-1:0];

  // unwritten entries read as zero
  assign rd_a = vld_a_r ? rdata_a : '0;
  assign rd_b = vld_b_r ? rdata_b : '0;

  assign raddr_a = (state_r == S_RD || state_r == S_OUT) ? rd_idx_r : mi_r;
  assign raddr_b = mix_other;

  always_comb begin
    we    = 1'b0;
    waddr = mi_r;
    wdata = rd_a - rd_b;
    if (state_r == S_SEED) begin
      we = 1'b1;
      if (k_r == '0) begin
        waddr = skxc_pkg::LastIdx;
        wdata = seed_key_r;
      end else begin
        waddr = pos_nxt - IdxW'(1);
        wdata = cur_r;
      end
    end else if (state_r == S_MIX_WR) begin
      we = 1'b1;
    end
  end

  skxc_ram #(
    .Width (WordW),
    .Depth (skxc_pkg::TableWords)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    vld_a_r <= tbl_vld_r[raddr_a];
    vld_b_r <= tbl_vld_r[raddr_b];

    if (!rst_n) begin
      state_r    <= S_IDLE;
      seed_key_r <= '0;
      mix_pend_r <= 1'b1;
      rd_idx_r   <= '0;
      out_vld_r  <= 1'b0;
      for (int i = 0; i < skxc_pkg::TableWords; i++) begin
        tbl_vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_ch.valid) begin
        seed_key_r <= cfg_ch.seed_key;
      end
      if (we) begin
        tbl_vld_r[waddr] <= 1'b1;
      end
      if (out_vld_r && out_ch.ready && state_r != S_OUT) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r   <= skxc_pkg::op_t'(in_ch.opcode);
            data_r <= in_ch.data_word;
            last_r <= in_ch.last_word[0];
            if (skxc_pkg::op_t'(in_ch.opcode) == skxc_pkg::OP_REKEY) begin
              k_r     <= '0;
              pos_r   <= '0;
              prev_r  <= seed_key_r;
              cur_r   <= WordW'(1);
              state_r <= S_SEED;
            end else if (mix_pend_r) begin
              mi_r    <= '0;
              pass_r  <= skxc_pkg::CryptPasses;
              state_r <= S_MIX_RD;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_SEED: begin
          if (k_r != '0) begin
            pos_r  <= pos_nxt;
            prev_r <= cur_r;
            cur_r  <= prev_r - cur_r;
          end
          k_r <= k_r + IdxW'(1);
          if (k_r == skxc_pkg::LastIdx) begin
            mi_r       <= '0;
            pass_r     <= skxc_pkg::RekeyPasses;
            mix_pend_r <= 1'b1;
            state_r    <= S_MIX_RD;
          end
        end
        S_MIX_RD: begin
          state_r <= S_MIX_WR;
        end
        S_MIX_WR: begin
          if (mi_r == skxc_pkg::LastIdx) begin
            mi_r <= '0;
            if (pass_r != '0) begin
              pass_r  <= pass_r - 2'd1;
              state_r <= S_MIX_RD;
            end else if (op_r == skxc_pkg::OP_REKEY) begin
              state_r <= S_OUT;
            end else begin
              mix_pend_r <= 1'b0;
              rd_idx_r   <= '0;
              state_r    <= S_RD;
            end
          end else begin
            mi_r    <= mi_r + IdxW'(1);
            state_r <= S_MIX_RD;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_vld_r  <= 1'b1;
            last_out_r <= last_r;
            if (op_r == skxc_pkg::OP_CRYPT) begin
              result_r <= data_r ^ rd_a;
              if (rd_idx_r == skxc_pkg::LastIdx) begin
                mix_pend_r <= 1'b1;
              end else begin
                rd_idx_r <= rd_idx_r + IdxW'(1);
              end
            end else begin
              result_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.result_word = result_r;
  assign out_ch.last_out    = last_out_r;

endmodule

`default_nettype wire
